[design/length_prefixed_frame_receiver_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame receiver
// Property wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication
`define LPFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LPFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lpfr_pkg.sv]
// ----------------------------------------------------------------------------
// lpfr_pkg
// Shared widths, codes and types of the length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package lpfr_pkg;

  localparam int unsigned RX_W    = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned AVAIL_W = 12;
  localparam int unsigned SEQ_W   = 24;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned REG_W   = CFG_AW - 2;

  localparam int unsigned FRAME_MAX_DEF  = 512;
  localparam int unsigned FIFO_DEPTH_DEF = 2048;

  // request codes
  localparam logic REQ_RX  = 1'b0;
  localparam logic REQ_POP = 1'b1;

  // register word index
  localparam logic [REG_W-1:0] REG_START_SEQ = REG_W'(0);

  // start bytes to match before the length field
  localparam logic [1:0] MATCH_LEN = 2'd3;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } rx_phase_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_POP,
    SQ_COPY,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic [RX_W-1:0] pop_data;
    logic            pop_valid;
    logic            frame_stored;
    logic            frame_dropped;
  } res_t;

endpackage

[design/lpfr_if.sv]
// ----------------------------------------------------------------------------
// lpfr channel interfaces
// Valid/ready channels for requests and results of the frame receiver.
// ----------------------------------------------------------------------------
interface lpfr_in_if;
  import lpfr_pkg::*;

  logic            valid;
  logic            ready;
  logic            req_type;
  logic [RX_W-1:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lpfr_out_if;
  import lpfr_pkg::*;

  logic               valid;
  logic               ready;
  logic [RX_W-1:0]    pop_data;
  logic               pop_valid;
  logic               frame_stored;
  logic               frame_dropped;
  logic [AVAIL_W-1:0] bytes_available;

  modport source (output valid, output pop_data, output pop_valid, output frame_stored,
                  output frame_dropped, output bytes_available, input ready);
  modport sink   (input valid, input pop_data, input pop_valid, input frame_stored,
                  input frame_dropped, input bytes_available, output ready);
endinterface

[design/lpfr_frame_buf.sv]
// ----------------------------------------------------------------------------
// lpfr_frame_buf
// Payload staging memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpfr_frame_buf #(
  parameter int unsigned DEPTH = lpfr_pkg::FRAME_MAX_DEF,
  parameter int unsigned AW    = $clog2(lpfr_pkg::FRAME_MAX_DEF)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lpfr_pkg::RX_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [lpfr_pkg::RX_W-1:0] rd_data
);
  import lpfr_pkg::*;

  logic [RX_W-1:0] mem [DEPTH];

  // store payload bytes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read for the copy engine
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/lpfr_byte_fifo.sv]
// ----------------------------------------------------------------------------
// lpfr_byte_fifo
// Circular byte FIFO with head/tail pointers, fill level and registered pop.
// ----------------------------------------------------------------------------
module lpfr_byte_fifo #(
  parameter int unsigned DEPTH   = lpfr_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned PTR_W   = $clog2(lpfr_pkg::FIFO_DEPTH_DEF),
  parameter int unsigned LEVEL_W = $clog2(lpfr_pkg::FIFO_DEPTH_DEF + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lpfr_pkg::fifo_ctl_t       ctl,
  input  logic [lpfr_pkg::RX_W-1:0] push_data,
  output logic [lpfr_pkg::RX_W-1:0] pop_data,
  output logic [LEVEL_W-1:0]        level
);
  import lpfr_pkg::*;

  logic [RX_W-1:0]    mem [DEPTH];
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;

  assign level = level_r;

  // advance pointers with wrap at the depth, track fill level
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    level_nxt = level_r;
    if (ctl.push) begin
      tail_nxt = (tail_r == PTR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (ctl.pop) begin
      head_nxt = (head_r == PTR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    priority if (ctl.push && !ctl.pop) begin
      level_nxt = level_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      level_nxt = level_r - 1'b1;
    end else begin
      level_nxt = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      level_r <= level_nxt;
    end
  end

  // write at tail, read at head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_data;
    end
    if (ctl.pop) begin
      pop_data <= mem[head_r];
    end
  end

endmodule

[design/length_prefixed_frame_receiver.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// Start-sequence hunter, length-prefixed deframer and byte FIFO with pop.
// ----------------------------------------------------------------------------
// Each request is either a received byte or a pop, and produces exactly one
// result beat. The block takes one request at a time and is not ready until
// its result sits in the output register. A received byte that does not end
// a frame, or a pop on an empty FIFO, goes from accept straight to the result
// state; any other pop goes through accept, FIFO memory read and result. A
// byte that completes a frame that fits starts a copy: a copy counter moves the
// frame from the staging buffer into the FIFO one byte per cycle over the
// buffer's single read port, then the read stage is drained and the finished
// copy is seen before the result. A dropped frame goes straight to the result
// state. A result beat that is not taken holds the block in its result state.
// There is no clearing pass after reset; memory entries are only read after
// being written. The start sequence register sits at byte address 0 of the
// APB port, first expected byte in bits 23:16.
module length_prefixed_frame_receiver #(
  parameter int unsigned FRAME_MAX  = lpfr_pkg::FRAME_MAX_DEF,
  parameter int unsigned FIFO_DEPTH = lpfr_pkg::FIFO_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lpfr_in_if.sink                     in_ch,
  lpfr_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpfr_pkg::CFG_AW-1:0] paddr,
  input  logic [lpfr_pkg::CFG_DW-1:0] pwdata,
  output logic [lpfr_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import lpfr_pkg::*;

  localparam int unsigned LEVEL_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FS_AW   = $clog2(FRAME_MAX);
  localparam int unsigned N_W     = $clog2(FRAME_MAX + 1);
  localparam int unsigned CNT_W   = LEN_W + 1;
  localparam int unsigned SUM_W   = ((LEVEL_W > CNT_W) ? LEVEL_W : CNT_W) + 1;

  seq_state_t         seq_r, seq_nxt;
  rx_phase_t          phase_r, phase_nxt;
  logic [LEN_W-1:0]   byte_count_r, byte_count_nxt;
  logic [LEN_W-1:0]   frame_length_r, frame_length_nxt;
  logic [RX_W-1:0]    length_high_r, length_high_nxt;
  logic [SEQ_W-1:0]   start_seq_r;
  res_t               res_r, res_nxt;
  logic [N_W-1:0]     copy_n_r, copy_n_nxt;
  logic [N_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;
  logic [AVAIL_W-1:0] out_avail_r, out_avail_nxt;

  logic               in_acc;
  logic               cfg_wr;
  logic [CNT_W-1:0]   cnt_inc;
  logic               fits;
  logic               issue;
  logic [RX_W-1:0]    expect_byte;
  logic [1:0]         match_inc;
  logic               fs_wr_en;
  logic               fs_rd_en;
  logic [FS_AW-1:0]   fs_rd_addr;
  logic [RX_W-1:0]    fs_rd_data;
  fifo_ctl_t          fifo_ctl;
  logic [RX_W-1:0]    fifo_rd_data;
  logic [LEVEL_W-1:0] level;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[CFG_AW-1:2] == REG_START_SEQ) ? CFG_DW'(start_seq_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_seq_r <= '0;
    end else if (cfg_wr && (paddr[CFG_AW-1:2] == REG_START_SEQ)) begin
      start_seq_r <= pwdata[SEQ_W-1:0];
    end
  end

  // ---- handshakes ----
  assign in_ch.ready = (seq_r == SQ_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.pop_data        = out_res_r.pop_data;
  assign out_ch.pop_valid       = out_res_r.pop_valid;
  assign out_ch.frame_stored    = out_res_r.frame_stored;
  assign out_ch.frame_dropped   = out_res_r.frame_dropped;
  assign out_ch.bytes_available = out_avail_r;

  // ---- datapath helpers ----
  assign cnt_inc = {1'b0, byte_count_r} + CNT_W'(1);
  assign fits    = (cnt_inc <= CNT_W'(FRAME_MAX)) &&
                   ((SUM_W'(level) + SUM_W'(cnt_inc)) <= SUM_W'(FIFO_DEPTH));
  assign issue   = (rd_idx_r != copy_n_r);
  assign match_inc = byte_count_r[1:0] + 2'd1;

  // select the next expected start byte
  always_comb begin
    unique case (byte_count_r[1:0])
      2'd1:    expect_byte = start_seq_r[15:8];
      2'd2:    expect_byte = start_seq_r[7:0];
      default: expect_byte = start_seq_r[23:16];
    endcase
  end

  // stage payload bytes that fit in the buffer
  assign fs_wr_en = in_acc && (in_ch.req_type == REQ_RX) && (phase_r == PH_DATA) &&
                    ({1'b0, byte_count_r} < CNT_W'(FRAME_MAX));

  // ---- sequencer and deframer ----
  always_comb begin
    seq_nxt          = seq_r;
    phase_nxt        = phase_r;
    byte_count_nxt   = byte_count_r;
    frame_length_nxt = frame_length_r;
    length_high_nxt  = length_high_r;
    res_nxt          = res_r;
    copy_n_nxt       = copy_n_r;
    rd_idx_nxt       = rd_idx_r;
    rd_pend_nxt      = rd_pend_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_res_nxt      = out_res_r;
    out_avail_nxt    = out_avail_r;
    fifo_ctl         = '0;
    fs_rd_en         = 1'b0;
    fs_rd_addr       = rd_idx_r[FS_AW-1:0];

    unique case (seq_r)
      SQ_IDLE: begin
        if (in_acc) begin
          res_nxt = '0;
          seq_nxt = SQ_DONE;
          if (in_ch.req_type == REQ_POP) begin
            // pop only from a non-empty FIFO
            if (level != '0) begin
              fifo_ctl.pop = 1'b1;
              seq_nxt      = SQ_POP;
            end
          end else begin
            unique case (phase_r)
              PH_LEN: begin
                if (byte_count_r == '0) begin
                  length_high_nxt = in_ch.rx_byte;
                  byte_count_nxt  = LEN_W'(1);
                end else begin
                  frame_length_nxt = {length_high_r, in_ch.rx_byte};
                  byte_count_nxt   = '0;
                  phase_nxt        = PH_DATA;
                end
              end
              PH_DATA: begin
                byte_count_nxt = cnt_inc[LEN_W-1:0];
                if (cnt_inc >= {1'b0, frame_length_r}) begin
                  // frame complete: copy it or drop it
                  byte_count_nxt   = '0;
                  frame_length_nxt = '0;
                  phase_nxt        = PH_HUNT;
                  if (fits) begin
                    res_nxt.frame_stored = 1'b1;
                    copy_n_nxt  = cnt_inc[N_W-1:0];
                    rd_idx_nxt  = '0;
                    rd_pend_nxt = 1'b0;
                    seq_nxt     = SQ_COPY;
                  end else begin
                    res_nxt.frame_dropped = 1'b1;
                  end
                end
              end
              default: begin
                // hunt: a mismatch restarts and discards the byte
                if (in_ch.rx_byte == expect_byte) begin
                  if (match_inc == MATCH_LEN) begin
                    byte_count_nxt = '0;
                    phase_nxt      = PH_LEN;
                  end else begin
                    byte_count_nxt = LEN_W'(match_inc);
                    phase_nxt      = PH_HUNT;
                  end
                end else begin
                  byte_count_nxt = '0;
                  phase_nxt      = PH_HUNT;
                end
              end
            endcase
          end
        end
      end
      SQ_POP: begin
        // capture the registered FIFO read
        res_nxt.pop_data  = fifo_rd_data;
        res_nxt.pop_valid = 1'b1;
        seq_nxt           = SQ_DONE;
      end
      SQ_COPY: begin
        // read one staged byte, push the previous one
        fs_rd_en      = issue;
        fifo_ctl.push = rd_pend_r;
        rd_pend_nxt   = issue;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
        if (!issue && !rd_pend_r) begin
          seq_nxt = SQ_DONE;
        end
      end
      SQ_DONE: begin
        // load the result once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_res_nxt   = res_r;
          out_avail_nxt = AVAIL_W'(level);
          out_valid_nxt = 1'b1;
          seq_nxt       = SQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r          <= SQ_IDLE;
      phase_r        <= PH_HUNT;
      byte_count_r   <= '0;
      frame_length_r <= '0;
      length_high_r  <= '0;
      copy_n_r       <= '0;
      rd_idx_r       <= '0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      seq_r          <= seq_nxt;
      phase_r        <= phase_nxt;
      byte_count_r   <= byte_count_nxt;
      frame_length_r <= frame_length_nxt;
      length_high_r  <= length_high_nxt;
      copy_n_r       <= copy_n_nxt;
      rd_idx_r       <= rd_idx_nxt;
      rd_pend_r      <= rd_pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // result payload holds without reset
  always_ff @(posedge clk) begin
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    out_avail_r <= out_avail_nxt;
  end

  // ---- storage ----
  lpfr_frame_buf #(
    .DEPTH (FRAME_MAX),
    .AW    (FS_AW)
  ) u_frame_buf (
    .clk     (clk),
    .wr_en   (fs_wr_en),
    .wr_addr (byte_count_r[FS_AW-1:0]),
    .wr_data (in_ch.rx_byte),
    .rd_en   (fs_rd_en),
    .rd_addr (fs_rd_addr),
    .rd_data (fs_rd_data)
  );

  lpfr_byte_fifo #(
    .DEPTH   (FIFO_DEPTH),
    .PTR_W   (PTR_W),
    .LEVEL_W (LEVEL_W)
  ) u_byte_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (fifo_ctl),
    .push_data (fs_rd_data),
    .pop_data  (fifo_rd_data),
    .level     (level)
  );

  // ---- assertions ----
`include "length_prefixed_frame_receiver_assert.svh"

  `LPFR_ASSERT_IMP(a_level_bound, 1'b1, level <= LEVEL_W'(FIFO_DEPTH), "FIFO level overflow")
  `LPFR_ASSERT_IMP(a_pop_nonempty, fifo_ctl.pop, level != '0, "pop from empty FIFO")
  `LPFR_ASSERT_NXT(a_busy_after_acc, in_acc, seq_r != SQ_IDLE, "accepted request left no work")
  `LPFR_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(seq_r) == SQ_DONE, "stray result")

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: length-prefixed frame receiver testbench
// Drives received bytes and pop requests over the request channel. A predictor
// of the hunter, deframer and byte FIFO steps once per accepted request, and
// every result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import lpfr_pkg::*;

  localparam int unsigned FRAME_MAX     = FRAME_MAX_DEF;
  localparam int unsigned FIFO_DEPTH    = FIFO_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = FRAME_MAX + 16;
  localparam logic [CFG_AW-1:0] START_SEQ_ADDR = CFG_AW'({REG_START_SEQ, 2'b00});

  typedef struct packed {
    logic [RX_W-1:0]    pop_data;
    logic               pop_valid;
    logic               frame_stored;
    logic               frame_dropped;
    logic [AVAIL_W-1:0] bytes_available;
  } rx_result_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  lpfr_in_if  req_bus ();
  lpfr_out_if res_bus ();

  length_prefixed_frame_receiver #(
    .FRAME_MAX  (FRAME_MAX),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (req_bus),
    .out_ch  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [SEQ_W-1:0] start_seq  = '0;
  rx_phase_t        rcv_phase  = PH_HUNT;
  int unsigned      rcv_count  = 0;
  int unsigned      rcv_len    = 0;
  logic [RX_W-1:0]  len_hi     = '0;
  logic [RX_W-1:0]  stage_copy [FRAME_MAX];
  logic [RX_W-1:0]  fifo_copy  [FIFO_DEPTH];
  int unsigned      fifo_count = 0;
  int unsigned      fifo_rd    = 0;
  int unsigned      fifo_wr    = 0;

  rx_result_t  pending_results [$];
  int          errors       = 0;
  int unsigned items_sent   = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  int          holdoff_len  = 0;
  logic        sink_hold    = 1'b0;
  int unsigned cycle_count  = 0;

  always #5 clk = ~clk;

  // abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic int unsigned next_slot(input int unsigned p);
    return (p == FIFO_DEPTH - 1) ? 0 : p + 1;
  endfunction

  // advance the predictor by one request and return the result it yields
  function automatic rx_result_t step_receiver(input logic req, input logic [RX_W-1:0] b);
    rx_result_t      r;
    logic [RX_W-1:0] want_byte;
    int unsigned     i;
    r = '0;
    if (req == REQ_POP) begin
      if (fifo_count != 0) begin
        r.pop_data  = fifo_copy[fifo_rd];
        r.pop_valid = 1'b1;
        fifo_rd     = next_slot(fifo_rd);
        fifo_count--;
      end
    end else if (rcv_phase == PH_LEN) begin
      if (rcv_count == 0) begin
        len_hi    = b;
        rcv_count = 1;
      end else begin
        rcv_len   = {len_hi, b};
        rcv_count = 0;
        rcv_phase = PH_DATA;
      end
    end else if (rcv_phase == PH_DATA) begin
      if (rcv_count < FRAME_MAX) stage_copy[rcv_count] = b;
      rcv_count++;
      if (rcv_count >= rcv_len) begin
        // push whole frame only if it was kept whole and fits
        if (rcv_count <= FRAME_MAX && fifo_count + rcv_count <= FIFO_DEPTH) begin
          for (i = 0; i < rcv_count; i++) begin
            fifo_copy[fifo_wr] = stage_copy[i];
            fifo_wr = next_slot(fifo_wr);
          end
          fifo_count += rcv_count;
          r.frame_stored = 1'b1;
        end else begin
          r.frame_dropped = 1'b1;
        end
        rcv_count = 0;
        rcv_len   = 0;
        rcv_phase = PH_HUNT;
      end
    end else begin
      // a mismatching byte restarts the hunt and is not looked at again
      want_byte = start_seq[8*(2-rcv_count) +: 8];
      if (b == want_byte && rcv_count < 3) rcv_count++;
      else rcv_count = 0;
      if (rcv_count == MATCH_LEN) begin
        rcv_count = 0;
        rcv_phase = PH_LEN;
      end
    end
    r.bytes_available = AVAIL_W'(fifo_count);
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  task automatic check_result();
    rx_result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual pop_data %0d avail %0d",
               $time, res_bus.pop_data, res_bus.bytes_available);
      errors++;
    end else begin
      want = pending_results.pop_front();
      if (res_bus.pop_data !== want.pop_data)
        flag_mismatch("pop_data", want.pop_data, res_bus.pop_data);
      if (res_bus.pop_valid !== want.pop_valid)
        flag_mismatch("pop_valid", want.pop_valid, res_bus.pop_valid);
      if (res_bus.frame_stored !== want.frame_stored)
        flag_mismatch("frame_stored", want.frame_stored, res_bus.frame_stored);
      if (res_bus.frame_dropped !== want.frame_dropped)
        flag_mismatch("frame_dropped", want.frame_dropped, res_bus.frame_dropped);
      if (res_bus.bytes_available !== want.bytes_available)
        flag_mismatch("bytes_available", want.bytes_available, res_bus.bytes_available);
    end
  endtask

  // result side: check each beat, stall at random or during a hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_bus.valid && res_bus.ready) check_result();
      res_bus.ready <= !sink_hold && ($urandom_range(99) >= snk_idle_pct);
    end else begin
      res_bus.ready <= 1'b0;
    end
  end

  // once holdoff_len is set, hold the result side off for that length
  always begin
    wait (holdoff_len != 0);
    repeat (holdoff_len) begin
      sink_hold <= 1'b1;
      @(posedge clk);
    end
    sink_hold <= 1'b0;
    holdoff_len = 0;
  end

  // offer one request beat, idling first at random, and predict its result
  task automatic send_beat(input logic req, input logic [RX_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= req;
    req_bus.rx_byte  <= b;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pending_results.push_back(step_receiver(req, b));
    items_sent++;
  endtask

  // drop valid and hold until every predicted result has come back
  task automatic wait_all_results();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one APB transfer; the caller closes the bus afterwards
  task automatic apb_xfer(input logic wr, input logic [CFG_DW-1:0] wdata,
                          output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= START_SEQ_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  // write the start sequence while idle, then read it back
  task automatic program_start_seq(input logic [SEQ_W-1:0] seq);
    logic [CFG_DW-1:0] rd;
    wait_all_results();
    apb_xfer(1'b1, CFG_DW'(seq), rd);
    start_seq = seq;
    apb_xfer(1'b0, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (rd[SEQ_W-1:0] !== seq) begin
      $display("%0t: start_seq readback mismatch, expected %06h, actual %06h",
               $time, seq, rd[SEQ_W-1:0]);
      errors++;
    end
  endtask

  task automatic send_start_bytes(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_beat(REQ_RX, start_seq[8*(2-k) +: 8]);
  endtask

  // well-formed frame with random payload, pops mixed into the payload
  task automatic send_frame(input int unsigned len, input int pop_pct);
    int unsigned n;
    int unsigned k;
    send_start_bytes(3);
    send_beat(REQ_RX, RX_W'(len >> 8));
    send_beat(REQ_RX, RX_W'(len));
    n = (len == 0) ? 1 : len;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < pop_pct) send_beat(REQ_POP, RX_W'($urandom));
      send_beat(REQ_RX, RX_W'($urandom));
    end
  endtask

  task automatic test_directed();
    // all-zero start bytes, pop on empty, zero-length frame still takes a byte
    program_start_seq('0);
    send_beat(REQ_POP, 8'hFF);
    send_frame(0, 0);
    send_beat(REQ_POP, 8'h00);
    send_beat(REQ_POP, 8'h00);
    // all-ones start bytes, big-endian length, payload extremes
    program_start_seq('1);
    repeat (3) send_beat(REQ_RX, 8'hFF);
    send_beat(REQ_RX, 8'h00);
    send_beat(REQ_RX, 8'h02);
    send_beat(REQ_RX, 8'h00);
    send_beat(REQ_RX, 8'hFF);
    repeat (2) send_beat(REQ_POP, 8'hA5);
  endtask

  task automatic test_hunt_restart();
    program_start_seq(24'hAAAAAB);
    // third byte mismatches; the following AB is not taken as a fresh start
    send_beat(REQ_RX, 8'hAA);
    send_beat(REQ_RX, 8'hAA);
    send_beat(REQ_RX, 8'hAA);
    send_beat(REQ_RX, 8'hAB);
    send_start_bytes(3);
    send_beat(REQ_RX, 8'h00);
    send_beat(REQ_RX, 8'h00);
    send_beat(REQ_RX, 8'h5A);
    send_beat(REQ_POP, 8'h00);
  endtask

  task automatic test_large_frames();
    program_start_seq(SEQ_W'($urandom));
    while (fifo_count != 0) send_beat(REQ_POP, RX_W'($urandom));
    // frame at the staging limit is kept; one byte over is dropped
    send_frame(FRAME_MAX, 0);
    send_frame(FRAME_MAX + 1, 0);
  endtask

  task automatic test_backpressure();
    program_start_seq(SEQ_W'($urandom));
    holdoff_len = 300;
    send_frame(20, 20);
    repeat (10) send_beat(REQ_POP, RX_W'($urandom));
    wait_all_results();
  endtask

  task automatic test_random(input int src_pct, input int snk_pct,
                             input logic [SEQ_W-1:0] seq, input int unsigned target);
    int unsigned base;
    int unsigned r;
    int unsigned k;
    int unsigned n;
    int unsigned len;
    program_start_seq(seq);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    base = items_sent;
    while (items_sent - base < target) begin
      r = $urandom_range(99);
      if (r < 45) begin
        k = $urandom_range(99);
        if (k < 85) len = $urandom_range(24, 0);
        else len = $urandom_range(100, 25);
        send_frame(len, 8);
      end else if (r < 80) begin
        // pop harder when the FIFO runs deep
        n = (fifo_count > 256) ? $urandom_range(80, 16) : $urandom_range(8, 1);
        repeat (n) send_beat(REQ_POP, RX_W'($urandom));
      end else if (r < 90) begin
        repeat ($urandom_range(4, 1)) send_beat(REQ_RX, RX_W'($urandom));
      end else if (r < 95) begin
        // partial start sequence broken by a random byte
        send_start_bytes($urandom_range(2, 1));
        send_beat(REQ_RX, RX_W'($urandom));
      end else begin
        // truncated frame: whatever follows completes it
        len = $urandom_range(30, 5);
        send_start_bytes(3);
        send_beat(REQ_RX, RX_W'(len >> 8));
        send_beat(REQ_RX, RX_W'(len));
        repeat ($urandom_range(len - 1, 0)) send_beat(REQ_RX, RX_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    req_bus.valid    <= 1'b0;
    req_bus.req_type <= REQ_RX;
    req_bus.rx_byte  <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    src_idle_pct = 35;
    snk_idle_pct = 87;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_hunt_restart();
    test_large_frames();
    test_backpressure();
    test_random(35, 87, SEQ_W'($urandom), 100);
    test_random(87, 35, {3{RX_W'($urandom)}}, 100);
    test_random(0, 0, SEQ_W'($urandom), 100);

    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/lpfr_pkg.sv
design/lpfr_if.sv
design/lpfr_frame_buf.sv
design/lpfr_byte_fifo.sv
design/length_prefixed_frame_receiver.sv
dv/tb.sv
